FILE: rtl/ldd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldd_pkg: shared types and constants of the locate database decoder.
// Holds sizes, code values and the front-to-back command format.
// ----------------------------------------------------------------------------
package ldd_pkg;

  localparam int PathBytes       = 1024;
  localparam int PathAw          = $clog2(PathBytes);
  localparam int BigramEntries   = 128;
  localparam int TableBytes      = 2 * BigramEntries;
  localparam int TableAw         = $clog2(TableBytes);
  localparam int PatternBytes    = 8;
  localparam int EscapeWordBytes = 4;
  localparam int EscBits         = 8 * EscapeWordBytes;

  localparam logic [7:0] CountOffset = 8'd14;
  localparam logic [7:0] EscapeCode  = 8'd30;
  localparam logic [7:0] BigramMark  = 8'd128;

  localparam logic [0:0] CfgPatternBytes  = 1'b0;
  localparam logic [0:0] CfgPatternLength = 1'b1;

  localparam logic [1:0] FaultNone = 2'd0;
  localparam logic [1:0] FaultSat  = 2'd1;
  localparam logic [1:0] FaultOvf  = 2'd2;

  typedef enum logic [1:0] {
    CmdLit   = 2'd0,
    CmdPair  = 2'd1,
    CmdCount = 2'd2
  } cmd_op_e;

  // Command passed from the front part to the back part.
  typedef struct packed {
    cmd_op_e            op;
    logic [7:0]         chr;
    logic [TableAw-2:0] entry;
    logic signed [EscBits:0] delta;
  } cmd_t;

endpackage

FILE: rtl/ldd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldd_if: valid/ready channel interfaces.
// A byte channel, a result channel and a configuration write channel.
// ----------------------------------------------------------------------------
interface ldd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  modport source (output valid, output code_byte, input ready);
  modport sink (input valid, input code_byte, output ready);
endinterface

interface ldd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [9:0]  position;
  logic [7:0]  first_char;
  logic [7:0]  second_char;
  logic [1:0]  char_count;
  logic [10:0] path_length;
  logic        pattern_found;
  logic [1:0]  fault;
  modport source (output valid, output kind, output position, output first_char,
                  output second_char, output char_count, output path_length,
                  output pattern_found, output fault, input ready);
  modport sink (input valid, input kind, input position, input first_char,
                input second_char, input char_count, input path_length,
                input pattern_found, input fault, output ready);
endinterface

interface ldd_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/ldd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldd_ram: generic single-port RAM.
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module ldd_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: rtl/ldd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldd_front: byte classifier.
// Loads the bigram table, gathers escape words and issues commands.
// ----------------------------------------------------------------------------
module ldd_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ldd_in_if.sink                         in_if,
  output logic                           tbl_we_o,
  output logic [ldd_pkg::TableAw-1:0]    tbl_addr_o,
  output logic [7:0]                     tbl_data_o,
  output logic                           cmd_valid_o,
  input  logic                           cmd_ready_i,
  output ldd_pkg::cmd_t                  cmd_o
);
  localparam int LdW = ldd_pkg::TableAw + 1;
  localparam int EbW = $clog2(ldd_pkg::EscapeWordBytes + 1);

  logic [LdW-1:0]               load_q, load_d;
  logic [EbW-1:0]               left_q, left_d;
  logic [ldd_pkg::EscBits-1:0]  acc_q, acc_d;
  logic                         loading, fire;
  logic [ldd_pkg::EscBits-1:0]  word;

  assign loading    = !load_q[LdW-1];
  assign in_if.ready = loading || cmd_ready_i;
  assign fire       = in_if.valid && in_if.ready;
  assign tbl_we_o   = fire && loading;
  assign tbl_addr_o = load_q[LdW-2:0];
  assign tbl_data_o = in_if.code_byte;

  // The last escape byte enters at the top of the word.
  assign word = {in_if.code_byte, acc_q[ldd_pkg::EscBits-1:8]};

  // Classification of one byte.
  always_comb begin
    load_d      = load_q;
    left_d      = left_q;
    acc_d       = acc_q;
    cmd_valid_o = 1'b0;
    cmd_o.op    = ldd_pkg::CmdLit;
    cmd_o.chr   = in_if.code_byte;
    cmd_o.entry = in_if.code_byte[ldd_pkg::TableAw-2:0];
    cmd_o.delta = (ldd_pkg::EscBits + 1)'($signed({1'b0, in_if.code_byte}))
                - (ldd_pkg::EscBits + 1)'(ldd_pkg::CountOffset);
    if (loading) begin
      if (fire) load_d = load_q + 1'b1;
    end else if (left_q != '0) begin
      if (fire) begin
        acc_d  = word;
        left_d = left_q - 1'b1;
      end
      if (left_q == EbW'(1)) begin
        cmd_valid_o = in_if.valid;
        cmd_o.op    = ldd_pkg::CmdCount;
        cmd_o.delta = $signed({word[ldd_pkg::EscBits-1], word})
                    - (ldd_pkg::EscBits + 1)'(ldd_pkg::CountOffset);
      end
    end else if (in_if.code_byte < ldd_pkg::EscapeCode) begin
      cmd_valid_o = in_if.valid;
      cmd_o.op    = ldd_pkg::CmdCount;
    end else if (in_if.code_byte == ldd_pkg::EscapeCode) begin
      if (fire) left_d = EbW'(ldd_pkg::EscapeWordBytes);
    end else begin
      cmd_valid_o = in_if.valid;
      cmd_o.op    = in_if.code_byte[7] ? ldd_pkg::CmdPair : ldd_pkg::CmdLit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
      left_q <= '0;
      acc_q  <= '0;
    end else begin
      load_q <= load_d;
      left_q <= left_d;
      acc_q  <= acc_d;
    end
  end
endmodule

FILE: rtl/ldd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldd_queue: two-entry command queue.
// Decouples the classifier from the path engine.
// ----------------------------------------------------------------------------
module ldd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ldd_pkg::cmd_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ldd_pkg::cmd_t out_data_o
);
  ldd_pkg::cmd_t mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = mem_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: rtl/ldd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldd_back: path engine.
// Writes characters to the path buffer and scans closed paths for the pattern.
// ----------------------------------------------------------------------------
module ldd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  ldd_pkg::cmd_t               cmd_i,
  output logic [ldd_pkg::TableAw-1:0] tbl_addr_o,
  input  logic [7:0]                  tbl_rdata_i,
  input  logic [63:0]                 pat_bytes_i,
  input  logic [3:0]                  pat_len_i,
  ldd_out_if.source                   out_if
);
  localparam int Aw = ldd_pkg::PathAw;
  localparam int Pw = Aw + 1;
  localparam int Dw = ldd_pkg::EscBits + 1;

  typedef enum logic [7:0] {
    SIdle  = 8'b00000001,
    STbl0  = 8'b00000010,
    STbl1  = 8'b00000100,
    SWr2   = 8'b00001000,
    SScan  = 8'b00010000,
    SCmp   = 8'b00100000,
    SDone  = 8'b01000000,
    SEmit  = 8'b10000000
  } state_e;

  state_e         st_q, st_d;
  ldd_pkg::cmd_t  cmd_q;
  logic [Aw-1:0]  prefix_q;
  logic [Pw-1:0]  wpos_q;
  logic           prev_q, open_q;
  logic [7:0]     c1_q;
  logic [Pw-1:0]  s_q;
  logic [3:0]     k_q, plen;
  logic           found_q;
  logic [7:0]     want;

  // Path buffer port.
  logic           pb_we;
  logic [Aw-1:0]  pb_addr;
  logic [7:0]     pb_wdata, pb_rdata;
  ldd_ram #(.Width(8), .Depth(ldd_pkg::PathBytes)) u_path (
    .clk_i, .we_i(pb_we), .addr_i(pb_addr), .wdata_i(pb_wdata), .rdata_o(pb_rdata)
  );

  // Output register.
  logic        ov_q, kind_q, pf_q;
  logic [9:0]  pos_q;
  logic [7:0]  fc_q, sc_q;
  logic [1:0]  cc_q, flt_q;
  logic [10:0] len_q;

  assign out_if.valid         = ov_q;
  assign out_if.kind          = kind_q;
  assign out_if.position      = pos_q;
  assign out_if.first_char    = fc_q;
  assign out_if.second_char   = sc_q;
  assign out_if.char_count    = cc_q;
  assign out_if.path_length   = len_q;
  assign out_if.pattern_found = pf_q;
  assign out_if.fault         = flt_q;

  assign cmd_ready_o = (st_q == SIdle) && !ov_q;

  always_comb begin
    if (pat_len_i == 4'd0) plen = 4'd1;
    else if (pat_len_i > 4'(ldd_pkg::PatternBytes)) plen = 4'(ldd_pkg::PatternBytes);
    else plen = pat_len_i;
  end

  // k_q counts pattern characters from one, so character k_q - 1 is compared.
  assign want = pat_bytes_i[{3'(k_q - 4'd1), 3'b000} +: 8];

  // New prefix with clamping.
  logic signed [Dw:0] np_sum;
  logic [Aw-1:0]      np;
  logic               np_sat;
  always_comb begin
    np_sum = $signed({2'b00, {(Dw-Aw-1){1'b0}}, prefix_q}) + $signed({cmd_q.delta[Dw-1], cmd_q.delta});
    np_sat = 1'b0;
    np     = np_sum[Aw-1:0];
    if (np_sum < 0) begin
      np = '0; np_sat = 1'b1;
    end else if (np_sum > (Dw+1)'(ldd_pkg::PathBytes - 1)) begin
      np = '1; np_sat = 1'b1;
    end
  end

  // Current scan index s - k, and its validity.
  logic [Pw-1:0] idx;
  logic          idx_ok;
  assign idx    = s_q - Pw'(k_q);
  assign idx_ok = (s_q >= Pw'(k_q));

  logic ovf;
  assign ovf = wpos_q[Aw];
  assign tbl_addr_o = {cmd_q.entry, (st_q == STbl1)};

  always_comb begin
    st_d     = st_q;
    pb_we    = 1'b0;
    pb_addr  = wpos_q[Aw-1:0];
    pb_wdata = cmd_q.chr;
    unique case (st_q)
      SIdle:  if (cmd_valid_i && cmd_ready_o) begin
        unique case (cmd_i.op)
          ldd_pkg::CmdLit:   st_d = SEmit;
          ldd_pkg::CmdPair:  st_d = STbl0;
          ldd_pkg::CmdCount: st_d = SScan;
          default:           st_d = SEmit;
        endcase
      end
      STbl0:  st_d = STbl1;
      STbl1:  begin
        pb_wdata = tbl_rdata_i;
        pb_we    = !ovf;
        st_d     = SWr2;
      end
      SWr2:   begin
        pb_wdata = tbl_rdata_i;
        pb_we    = !ovf;
        st_d     = SEmit;
      end
      SScan:  begin
        pb_addr = idx[Aw-1:0];
        st_d = SCmp;
      end
      SCmp:   st_d = SScan;
      SDone:  st_d = SIdle;
      SEmit:  st_d = SIdle;
      default: st_d = SIdle;
    endcase
    if (st_q == SEmit && cmd_q.op == ldd_pkg::CmdLit) pb_we = !ovf;
    if (st_q == SScan) begin
      if (!open_q || found_q || s_q == '0 ||
          (!prev_q && s_q <= Pw'(prefix_q))) st_d = SDone;
      else if (!idx_ok) st_d = SScan;
      else pb_addr = idx[Aw-1:0];
    end
  end

  // Scan: s_q holds candidate end plus one; as k_q rises, s - k walks back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= SIdle;
      prefix_q <= '0;
      wpos_q   <= '0;
      prev_q   <= 1'b0;
      open_q   <= 1'b0;
      ov_q     <= 1'b0;
      found_q  <= 1'b0;
      s_q      <= '0;
      k_q      <= '0;
    end else begin
      st_q <= st_d;
      if (ov_q && out_if.ready) ov_q <= 1'b0;
      unique case (st_q)
        SIdle: if (cmd_valid_i && cmd_ready_o) begin
          cmd_q   <= cmd_i;
          pos_q   <= wpos_q[9:0];
          found_q <= 1'b0;
          s_q     <= wpos_q;
          k_q     <= 4'd1;
        end
        STbl0: ;
        STbl1: begin
          c1_q <= tbl_rdata_i;
          if (!ovf) wpos_q <= wpos_q + 1'b1;
        end
        SWr2: begin
          kind_q <= 1'b0; fc_q <= c1_q; sc_q <= tbl_rdata_i;
          len_q <= '0; pf_q <= 1'b0;
          cc_q  <= 2'(wpos_q - Pw'(pos_q)) + {1'b0, !ovf};
          flt_q <= (ovf) ? ldd_pkg::FaultOvf : ldd_pkg::FaultNone;
          if (!ovf) wpos_q <= wpos_q + 1'b1;
          ov_q <= 1'b1;
        end
        SScan: if (!(!open_q || found_q || s_q == '0 ||
                     (!prev_q && s_q <= Pw'(prefix_q))) && !idx_ok) begin
          s_q <= s_q - 1'b1; k_q <= 4'd1;
        end
        SCmp: begin
          if (pb_rdata != want) begin
            s_q <= s_q - 1'b1; k_q <= 4'd1;
          end else if (k_q == plen) begin
            found_q <= 1'b1;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        SDone: begin
          kind_q <= 1'b1; pos_q <= '0; fc_q <= '0; sc_q <= '0; cc_q <= '0;
          len_q <= 11'(wpos_q); pf_q <= found_q;
          flt_q <= np_sat ? ldd_pkg::FaultSat : ldd_pkg::FaultNone;
          ov_q  <= open_q;
          if (open_q) prev_q <= found_q;
          open_q   <= 1'b1;
          prefix_q <= np;
          wpos_q   <= {1'b0, np};
        end
        SEmit: if (cmd_q.op == ldd_pkg::CmdLit) begin
          kind_q <= 1'b0; fc_q <= cmd_q.chr; sc_q <= '0;
          len_q <= '0; pf_q <= 1'b0;
          cc_q  <= {1'b0, !ovf};
          flt_q <= ovf ? ldd_pkg::FaultOvf : ldd_pkg::FaultNone;
          if (!ovf) wpos_q <= wpos_q + 1'b1;
          ov_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: rtl/locate_database_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// locate_database_decoder_core: locate database decoder top level.
// A literal is written in SEmit; a pair reads both table bytes in STbl0 and STbl1,
// writing them in STbl1 and SWr2. Table bytes are written as they arrive. A path
// completion scans the buffer backward, an SScan and an SCmp for each candidate
// position and each matching pattern character, set by the single buffer port. The
// engine starts its next item once the result is taken. Reset is asynchronous, active
// low; table and buffer are undefined until written, all control state clears at once.
// ----------------------------------------------------------------------------
module locate_database_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  ldd_in_if.sink     in_if,
  ldd_out_if.source  out_if,
  ldd_cfg_if.sink    cfg_if
);
  logic [63:0] pat_bytes_q;
  logic [3:0]  pat_len_q;

  // Configuration registers.
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes_q <= 64'd47;
      pat_len_q   <= 4'd1;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        ldd_pkg::CfgPatternBytes:  pat_bytes_q <= cfg_if.data;
        ldd_pkg::CfgPatternLength: pat_len_q   <= cfg_if.data[3:0];
        default: ;
      endcase
    end
  end

  logic                        tbl_we;
  logic [ldd_pkg::TableAw-1:0] tbl_waddr, tbl_raddr;
  logic [7:0]                  tbl_wdata, tbl_rdata;
  logic                        f_valid, f_ready, b_valid, b_ready;
  ldd_pkg::cmd_t               f_cmd, b_cmd;

  ldd_front u_front (
    .clk_i, .rst_ni, .in_if,
    .tbl_we_o(tbl_we), .tbl_addr_o(tbl_waddr), .tbl_data_o(tbl_wdata),
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd)
  );

  // Table writes happen only before any command, so one port is shared.
  ldd_ram #(.Width(8), .Depth(ldd_pkg::TableBytes)) u_table (
    .clk_i, .we_i(tbl_we), .addr_i(tbl_we ? tbl_waddr : tbl_raddr),
    .wdata_i(tbl_wdata), .rdata_o(tbl_rdata)
  );

  ldd_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_data_i(f_cmd),
    .out_valid_o(b_valid), .out_ready_i(b_ready), .out_data_o(b_cmd)
  );

  ldd_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(b_valid), .cmd_ready_o(b_ready), .cmd_i(b_cmd),
    .tbl_addr_o(tbl_raddr), .tbl_rdata_i(tbl_rdata),
    .pat_bytes_i(pat_bytes_q), .pat_len_i(pat_len_q), .out_if
  );
endmodule
